// ----- rtl/dabp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and arithmetic helpers of the darken alpha blend unit.
// No dependencies; every other file imports it.
package dabp_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_COLORS = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int FRONT_STGS = 4;   // alpha, premultiply, products, darken
    localparam int DIV_STGS   = 4;   // un-premultiply divider
    localparam int DIV_BITS   = 2;   // quotient bits resolved per divider stage
    localparam int PIPE_STGS  = FRONT_STGS + DIV_STGS;
    localparam int NUM_W      = 17;  // 510*c + a
    localparam int DEN_W      = 9;   // 2*a

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_OPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_OPACITY = CFG_IDX_W'(1);
    localparam logic [CHAN_W-1:0]    OPACITY_RESET      = 8'd255;
    localparam logic [CHAN_W-1:0]    CHAN_MAX           = 8'd255;

    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        t_chan src_red;
        t_chan src_green;
        t_chan src_blue;
        t_chan src_alpha;
        t_chan dst_red;
        t_chan dst_green;
        t_chan dst_blue;
        t_chan dst_alpha;
    } t_in_word;

    typedef struct packed {
        t_chan out_red;
        t_chan out_green;
        t_chan out_blue;
        t_chan out_alpha;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        t_chan                value;
    } t_cfg_word;

    // round(a*b/255); x/255 for x below 65536 is (x + (x >> 8) + 1) >> 8
    function automatic t_chan mul8(input t_chan a, input t_chan b);
        logic [15:0] p;
        logic [16:0] x;
        logic [16:0] q;
        p = a * b;
        x = {1'b0, p} + 17'd127;
        q = (x + (x >> 8) + 17'd1) >> 8;
        return q[CHAN_W-1:0];
    endfunction

endpackage

// ----- rtl/dabp_in_if.sv -----
`timescale 1ns / 1ps
// Input pixel channel: source and destination RGBA word with valid/ready.
// Depends on dabp_pkg.
interface dabp_in_if;
    import dabp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dabp_out_if.sv -----
`timescale 1ns / 1ps
// Output pixel channel: blended RGBA word with valid/ready.
// Depends on dabp_pkg.
interface dabp_out_if;
    import dabp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dabp_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data with valid/ready.
// Depends on dabp_pkg.
interface dabp_cfg_if;
    import dabp_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/darken_alpha_blend_pixel_unit.sv -----
`timescale 1ns / 1ps
// Darken blend of two straight-alpha RGBA pixels with layer opacities.
// Eight-stage pipeline (four blend stages, four 2-bit divider stages); throughput one
// word per cycle while the output channel accepts words.
// Each stage holds only while it is full and the stage after it stalls.
// Reset (synchronous, active low) empties the pipeline and sets both opacities to 255.
module darken_alpha_blend_pixel_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dabp_in_if.sink    i_pix,
    dabp_out_if.source o_pix,
    dabp_cfg_if.sink   i_cfg
);
    import dabp_pkg::*;

    // configuration registers
    t_chan r_src_opac;
    t_chan r_tgt_opac;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_opac <= OPACITY_RESET;
            r_tgt_opac <= OPACITY_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.index == REG_SOURCE_OPACITY) begin
                r_src_opac <= i_cfg.data.value;
            end
            if (i_cfg.data.index == REG_TARGET_OPACITY) begin
                r_tgt_opac <= i_cfg.data.value;
            end
        end
    end

    // pipeline control: a stage loads when empty or when the next one loads
    logic [PIPE_STGS-1:0] r_vld;
    logic [PIPE_STGS:0]   en;

    always_comb begin
        en[PIPE_STGS] = o_pix.ready;
        for (int k = PIPE_STGS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < PIPE_STGS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: scaled alphas
    t_chan r1_sa, r1_da;
    t_chan r1_sc [NUM_COLORS];
    t_chan r1_dc [NUM_COLORS];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_sa    <= mul8(i_pix.data.src_alpha, r_src_opac);
            r1_da    <= mul8(i_pix.data.dst_alpha, r_tgt_opac);
            r1_sc[0] <= i_pix.data.src_red;
            r1_sc[1] <= i_pix.data.src_green;
            r1_sc[2] <= i_pix.data.src_blue;
            r1_dc[0] <= i_pix.data.dst_red;
            r1_dc[1] <= i_pix.data.dst_green;
            r1_dc[2] <= i_pix.data.dst_blue;
        end
    end

    // stage 2: premultiplied colors
    t_chan r2_sa, r2_da, r2_sada;
    t_chan r2_s [NUM_COLORS];
    t_chan r2_d [NUM_COLORS];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_sa   <= r1_sa;
            r2_da   <= r1_da;
            r2_sada <= mul8(r1_sa, r1_da);
            for (int i = 0; i < NUM_COLORS; i++) begin
                r2_s[i] <= mul8(r1_sc[i], r1_sa);
                r2_d[i] <= mul8(r1_dc[i], r1_da);
            end
        end
    end

    // stage 3: cross products and composite alpha
    t_chan       r3_s  [NUM_COLORS];
    t_chan       r3_d  [NUM_COLORS];
    t_chan       r3_ps [NUM_COLORS];
    t_chan       r3_pd [NUM_COLORS];
    t_chan       r3_ms [NUM_COLORS];
    t_chan       r3_md [NUM_COLORS];
    t_chan       r3_a;
    logic [8:0]  n_a;

    always_comb begin
        n_a = {1'b0, r2_sa} + {1'b0, r2_da} - {1'b0, r2_sada};
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_a <= n_a[8] ? CHAN_MAX : n_a[CHAN_W-1:0];
            for (int i = 0; i < NUM_COLORS; i++) begin
                r3_s[i]  <= r2_s[i];
                r3_d[i]  <= r2_d[i];
                r3_ps[i] <= mul8(r2_s[i], r2_da);
                r3_pd[i] <= mul8(r2_d[i], r2_sa);
                r3_ms[i] <= mul8(r2_d[i], CHAN_MAX - r2_sa);
                r3_md[i] <= mul8(r2_s[i], CHAN_MAX - r2_da);
            end
        end
    end

    // stage 4: keep the darker term, saturating add
    t_chan      r4_c [NUM_COLORS];
    t_chan      r4_a;
    logic [8:0] n_sum [NUM_COLORS];

    always_comb begin
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (r3_ps[i] < r3_pd[i]) begin
                n_sum[i] = {1'b0, r3_s[i]} + {1'b0, r3_ms[i]};
            end else begin
                n_sum[i] = {1'b0, r3_d[i]} + {1'b0, r3_md[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_a <= r3_a;
            for (int i = 0; i < NUM_COLORS; i++) begin
                r4_c[i] <= n_sum[i][8] ? CHAN_MAX : n_sum[i][CHAN_W-1:0];
            end
        end
    end

    // divider stages: round(c*255/a) = (510c + a) / (2a), restoring, 2 bits a stage
    logic [NUM_W-1:0]  r_rem  [DIV_STGS][NUM_COLORS];
    t_chan             r_quo  [DIV_STGS][NUM_COLORS];
    logic              r_sat  [DIV_STGS][NUM_COLORS];
    logic [DEN_W-1:0]  r_den  [DIV_STGS];
    logic              r_zero [DIV_STGS];
    t_chan             r_alp  [DIV_STGS];

    logic [NUM_W-1:0]  d_rem  [DIV_STGS][NUM_COLORS];
    t_chan             d_quo  [DIV_STGS][NUM_COLORS];
    logic              d_sat  [DIV_STGS][NUM_COLORS];
    logic [DEN_W-1:0]  d_den  [DIV_STGS];
    logic              d_zero [DIV_STGS];
    t_chan             d_alp  [DIV_STGS];

    always_comb begin
        d_den[0]  = {r4_a, 1'b0};
        d_zero[0] = (r4_a == '0);
        d_alp[0]  = r4_a;
        for (int i = 0; i < NUM_COLORS; i++) begin
            d_rem[0][i] = NUM_W'(r4_c[i]) * NUM_W'(510) + NUM_W'(r4_a);
            d_quo[0][i] = '0;
            // c >= a rounds to at least 255
            d_sat[0][i] = (r4_c[i] >= r4_a);
        end
        for (int k = 1; k < DIV_STGS; k++) begin
            d_den[k]  = r_den[k-1];
            d_zero[k] = r_zero[k-1];
            d_alp[k]  = r_alp[k-1];
            for (int i = 0; i < NUM_COLORS; i++) begin
                d_rem[k][i] = r_rem[k-1][i];
                d_quo[k][i] = r_quo[k-1][i];
                d_sat[k][i] = r_sat[k-1][i];
            end
        end
    end

    for (genvar gk = 0; gk < DIV_STGS; gk++) begin : g_div
        logic [NUM_W-1:0] n_rem [NUM_COLORS];
        t_chan            n_quo [NUM_COLORS];

        always_comb begin
            logic [NUM_W-1:0] sub;
            for (int i = 0; i < NUM_COLORS; i++) begin
                n_rem[i] = d_rem[gk][i];
                n_quo[i] = d_quo[gk][i];
                for (int b = 0; b < DIV_BITS; b++) begin
                    sub = NUM_W'(d_den[gk]) << (CHAN_W - 1 - DIV_BITS * gk - b);
                    if (n_rem[i] >= sub) begin
                        n_rem[i] = n_rem[i] - sub;
                        n_quo[i][CHAN_W - 1 - DIV_BITS * gk - b] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[FRONT_STGS + gk]) begin
                r_den[gk]  <= d_den[gk];
                r_zero[gk] <= d_zero[gk];
                r_alp[gk]  <= d_alp[gk];
                for (int i = 0; i < NUM_COLORS; i++) begin
                    r_rem[gk][i] <= n_rem[i];
                    r_quo[gk][i] <= n_quo[i];
                    r_sat[gk][i] <= d_sat[gk][i];
                end
            end
        end
    end

    // output word
    t_chan out_c [NUM_COLORS];

    always_comb begin
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (r_zero[DIV_STGS-1]) begin
                out_c[i] = '0;
            end else if (r_sat[DIV_STGS-1][i]) begin
                out_c[i] = CHAN_MAX;
            end else begin
                out_c[i] = r_quo[DIV_STGS-1][i];
            end
        end
    end

    assign o_pix.valid          = r_vld[PIPE_STGS-1];
    assign o_pix.data.out_red   = out_c[0];
    assign o_pix.data.out_green = out_c[1];
    assign o_pix.data.out_blue  = out_c[2];
    assign o_pix.data.out_alpha = r_alp[DIV_STGS-1];

endmodule
